[rtl/core/frsd_pkg.sv]
// Shared constants, types and the command interface of the frequency rank decoder.
package frsd_pkg;

	localparam int COUNT_BITS    = 20;
	localparam int ALPHABET_SIZE = 32;
	localparam int SYM_BITS      = $clog2(ALPHABET_SIZE);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SYM_BITS-1:0]   sym_t;
	typedef logic [1:0]            mode_t;

	localparam mode_t MODE_COUNT  = 2'd0;
	localparam mode_t MODE_DECODE = 2'd1;
	localparam mode_t MODE_CLEAR  = 2'd2;

	// Source of the histogram read address.
	typedef enum logic [1:0] {
		RD_SYM_IN = 2'd0,
		RD_KEY    = 2'd1,
		RD_ZERO   = 2'd2,
		RD_NEXT   = 2'd3
	} rd_src_t;

	typedef struct packed {
		logic    cap;
		logic    rd_en;
		rd_src_t rd_src;
		logic    cnt_wr;
		logic    hist_clr;
		logic    key_clr;
		logic    ld_key;
		logic    scan;
		logic    tbl_wr;
		logic    out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic key_last;
		logic out_free;
	} dp_stat_t;

	// Plaintext letters in expected order of frequency, most common first.
	localparam sym_t FREQ_ORDER [ALPHABET_SIZE] = '{
		5'd14, 5'd5,  5'd0,  5'd8,  5'd13, 5'd18, 5'd17, 5'd16,
		5'd2,  5'd11, 5'd10, 5'd12, 5'd4,  5'd15, 5'd19, 5'd31,
		5'd27, 5'd28, 5'd3,  5'd7,  5'd1,  5'd23, 5'd9,  5'd21,
		5'd6,  5'd24, 5'd30, 5'd22, 5'd25, 5'd29, 5'd20, 5'd26
	};

endpackage

[rtl/core/frsd_ram.sv]
// Generic single write port RAM with one registered read port.
module frsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/frsd_dp.sv]
// Datapath: histogram, rank counters, key table and output register.
module frsd_dp
	import frsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  sym_t     symbol,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  logic     out_stall,
	output logic     out_valid,
	output sym_t     plain_symbol
);

	sym_t                     sym_q;
	sym_t                     rd_addr;
	sym_t                     rd_addr_q;
	logic [ALPHABET_SIZE-1:0] hist_vld_q;
	count_t                   ram_rdata;
	count_t                   eff_count;
	count_t                   cnt_inc;
	count_t                   ck_q;
	sym_t                     j_q;
	sym_t                     k_q;
	sym_t                     rank_q;
	logic                     beats;
	sym_t                     tbl_q [ALPHABET_SIZE];
	logic                     out_valid_q;
	sym_t                     plain_q;

	always_comb begin
		unique case (cmd.rd_src)
			RD_SYM_IN: rd_addr = symbol;
			RD_KEY:    rd_addr = k_q;
			RD_ZERO:   rd_addr = '0;
			RD_NEXT:   rd_addr = j_q + sym_t'(1);
			default:   rd_addr = '0;
		endcase
	end

	frsd_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(ALPHABET_SIZE)
	) u_hist (
		.clk  (clk),
		.we   (cmd.cnt_wr),
		.waddr(sym_q),
		.wdata(cnt_inc),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// A bin never written since reset or clear reads as zero.
	assign eff_count = hist_vld_q[rd_addr_q] ? ram_rdata : '0;
	assign cnt_inc   = (&eff_count) ? eff_count : eff_count + count_t'(1);

	// Letter j ranks ahead of letter k on a larger count, or on a tie at a lower index.
	assign beats = (eff_count > ck_q) || ((eff_count == ck_q) && (j_q < k_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q   <= '0;
			hist_vld_q  <= '0;
			j_q         <= '0;
			k_q         <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_addr_q <= rd_addr;
			end
			if (cmd.hist_clr) begin
				hist_vld_q <= '0;
			end else if (cmd.cnt_wr) begin
				hist_vld_q[sym_q] <= 1'b1;
			end
			if (cmd.ld_key) begin
				j_q    <= '0;
				rank_q <= '0;
			end else if (cmd.scan) begin
				j_q    <= j_q + sym_t'(1);
				rank_q <= rank_q + sym_t'(beats);
			end
			if (cmd.key_clr) begin
				k_q <= '0;
			end else if (cmd.tbl_wr) begin
				k_q <= k_q + sym_t'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			sym_q <= symbol;
		end
		if (cmd.ld_key) begin
			ck_q <= eff_count;
		end
		if (cmd.tbl_wr) begin
			tbl_q[k_q] <= FREQ_ORDER[rank_q];
		end
		if (cmd.out_ld) begin
			plain_q <= tbl_q[sym_q];
		end
	end

	assign stat.scan_last = &j_q;
	assign stat.key_last  = &k_q;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign plain_symbol = plain_q;

endmodule

[rtl/core/frsd_ctrl.sv]
// Controller: sequences counting, ranking and decoding over the datapath.
module frsd_ctrl
	import frsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  mode_t    mode,
	output logic     in_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_CNT_WR  = 7'b0000010,
		ST_RK_RDK  = 7'b0000100,
		ST_RK_LDK  = 7'b0001000,
		ST_RK_SCAN = 7'b0010000,
		ST_RK_WR   = 7'b0100000,
		ST_DEC_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   key_ready_q;
	logic   key_ready_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		key_ready_d = key_ready_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.cap = 1'b1;
					unique case (mode)
						MODE_COUNT: begin
							cmd.rd_en   = 1'b1;
							cmd.rd_src  = RD_SYM_IN;
							key_ready_d = 1'b0;
							state_d     = ST_CNT_WR;
						end
						MODE_DECODE: begin
							if (key_ready_q) begin
								state_d = ST_DEC_OUT;
							end else begin
								cmd.key_clr = 1'b1;
								state_d     = ST_RK_RDK;
							end
						end
						MODE_CLEAR: begin
							cmd.hist_clr = 1'b1;
							key_ready_d  = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_CNT_WR: begin
				cmd.cnt_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RK_RDK: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_KEY;
				state_d    = ST_RK_LDK;
			end
			ST_RK_LDK: begin
				cmd.ld_key = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_ZERO;
				state_d    = ST_RK_SCAN;
			end
			ST_RK_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_NEXT;
				if (stat.scan_last) begin
					state_d = ST_RK_WR;
				end
			end
			ST_RK_WR: begin
				cmd.tbl_wr = 1'b1;
				if (stat.key_last) begin
					key_ready_d = 1'b1;
					state_d     = ST_DEC_OUT;
				end else begin
					state_d = ST_RK_RDK;
				end
			end
			ST_DEC_OUT: begin
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_ready_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			key_ready_q <= key_ready_d;
		end
	end

endmodule

[rtl/core/frequency_rank_substitution_decoder.sv]
// Top level of the frequency rank substitution decoder.
//
// The input channel (in_valid, in_stall, mode, symbol) takes one transfer per
// item. A count item adds the ciphertext letter to a histogram of saturating
// counters; it holds in_stall high for one cycle for the read-modify-write of
// the histogram RAM, so the next letter waits until that write is done.
// A clear item empties the histogram and drops the key without raising
// in_stall; an item with the unused mode is dropped likewise.
// A decode item produces one transfer on the output channel (out_valid,
// out_stall, plain_symbol). With a built key the controller moves to
// ST_DEC_OUT and loads the output register once it is free. The first decode
// after any counting, clear or reset first ranks all 32 letters: each letter is
// compared against every letter through the single histogram read port, in the
// states ST_RK_RDK, ST_RK_LDK, ST_RK_SCAN and ST_RK_WR for each letter.
// The output register holds a result while out_stall is high; a following
// count or clear item is still taken meanwhile, and a later decode waits in
// the controller until the register is free.
// Reset (arst_n low, asynchronous) empties the histogram at once through
// per-bin valid flags and marks the key as not built; no clearing pass runs.
module frequency_rank_substitution_decoder
	import frsd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  mode_t mode,
	input  sym_t  symbol,
	output logic  out_valid,
	input  logic  out_stall,
	output sym_t  plain_symbol
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller owns sequencing and the key-built flag.
	frsd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.mode    (mode),
		.in_stall(in_stall),
		.cmd     (cmd),
		.stat    (stat)
	);

	// The datapath holds the histogram, the ranking counters and the key table.
	frsd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.symbol      (symbol),
		.cmd         (cmd),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.plain_symbol(plain_symbol)
	);

endmodule

[rtl/core/frsd_checker.sv]
// Port-level checks of the frequency rank substitution decoder and their binding.
module frsd_checker
	import frsd_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_stall,
	input mode_t mode,
	input logic  out_valid,
	input logic  out_stall,
	input sym_t  plain_symbol
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_symbol))
		else $error("result changed while stalled");

	// Items other than decodes never raise a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (mode != MODE_DECODE) && !out_valid |=> !out_valid)
		else $error("result without a decode item");

	// Count and decode items leave the block busy, with in_stall raised, once they are taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && ((mode == MODE_COUNT) || (mode == MODE_DECODE)) |=> in_stall)
		else $error("block free right after a count or decode transfer");

	// A clear finishes in the cycle it is taken.
	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (mode == MODE_CLEAR) |=> !in_stall)
		else $error("block busy after a clear");

endmodule

bind frequency_rank_substitution_decoder frsd_checker u_frsd_checker (.*);
